// File: rtl/core/ptc_pkg.sv
// Shared constants, register map and fixed-point helpers for the pressure/temperature compensator.
package ptc_pkg;

    // Configuration register map
    typedef enum logic [2:0] {
        RegTempCoefPair  = 3'd0,
        RegPressOffset   = 3'd1,
        RegPressLinear   = 3'd2,
        RegTempCross     = 3'd3,
        RegMixedLinear   = 3'd4,
        RegPressSquare   = 3'd5,
        RegMixedSquare   = 3'd6,
        RegPressCube     = 3'd7
    } reg_index_t;

    // Pressure scale is 3 * 2^19, temperature scale is 2^19.
    localparam int DivShift   = 19;
    localparam int RecipShift = 33;
    // ceil(2^33 / 3): exact floor(n / 3) for any n below 2^32
    localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;
    localparam logic signed [47:0] TruncBias = (48'sd1 <<< DivShift) - 48'sd1;

    // x / 2^19, truncated toward zero
    function automatic logic signed [47:0] trunc_shr(input logic signed [47:0] x);
        return (x + (x[47] ? TruncBias : 48'sd0)) >>> DivShift;
    endfunction

    // |x| / 2^19, truncated
    function automatic logic [28:0] mag_shr(input logic signed [47:0] x);
        logic [47:0] m;
        m = x[47] ? 48'(-x) : 48'(x);
        return 29'(m >> DivShift);
    endfunction

    // floor(n / 3) by reciprocal multiply
    function automatic logic [27:0] div3(input logic [28:0] n);
        logic [60:0] prod;
        prod = 61'(n) * 61'(Recip3);
        return prod[60:RecipShift];
    endfunction

    // restore the sign of a magnitude quotient
    function automatic logic signed [28:0] apply_sign(input logic [27:0] q, input logic neg);
        logic signed [28:0] v;
        v = signed'({1'b0, q});
        return neg ? -v : v;
    endfunction

endpackage

// File: rtl/core/pressure_temperature_compensation.sv
// Top level: pipelined polynomial pressure and temperature compensation.
//
// Each transfer on the input channel carries one raw pressure / raw temperature pair
// (24-bit two's complement each) and yields exactly one transfer on the output channel:
// compensated pressure in pascal (low 32 bits of the full-precision value) and
// temperature in whole degrees. The pipeline is 13 register stages deep; out_valid for a
// pair rises once that pair has passed through every stage. A new pair is taken every cycle;
// throughput is one pair per clock, limited only by the output side holding ready low,
// which freezes the whole pipeline without losing or repeating anything. Each nested
// division by 1572864 (3 * 2^19) costs four stages: a multiply of up to 24x22 bits,
// magnitude and shift by 19, a 32-bit reciprocal multiply for the divide by 3, then sign
// restore plus the next coefficient. Three such levels plus the final sum set the latency.
// Calibration registers are written through the configuration channel, which is always
// ready; write them only while no transfer is in flight. Indexes: 0 packed c0/c1,
// 1 c00, 2 c10, 3 c01, 4 c11, 5 c20, 6 c21, 7 c30; all reset to zero.
module pressure_temperature_compensation (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] raw_pressure,
    input  logic signed [23:0] raw_temperature,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] comp_pressure,
    output logic signed [16:0] temperature_deg
);

    localparam int Stages = 13;

    // ---------------- calibration registers ----------------
    logic [23:0]        coef_pair_reg;
    logic signed [19:0] c00_reg;
    logic signed [19:0] c10_reg;
    logic signed [15:0] c01_reg;
    logic signed [15:0] c11_reg;
    logic signed [15:0] c20_reg;
    logic signed [15:0] c21_reg;
    logic signed [15:0] c30_reg;

    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [10:0] c0_half;

    assign cfg_ready = 1'b1;
    assign c0        = signed'(coef_pair_reg[23:12]);
    assign c1        = signed'(coef_pair_reg[11:0]);
    assign c0_half   = 11'(c0 >>> 1);   // rounds toward minus infinity

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair_reg <= '0;
            c00_reg       <= '0;
            c10_reg       <= '0;
            c01_reg       <= '0;
            c11_reg       <= '0;
            c20_reg       <= '0;
            c21_reg       <= '0;
            c30_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ptc_pkg::reg_index_t'(cfg_index))
                ptc_pkg::RegTempCoefPair: coef_pair_reg <= cfg_data;
                ptc_pkg::RegPressOffset:  c00_reg <= signed'(cfg_data[19:0]);
                ptc_pkg::RegPressLinear:  c10_reg <= signed'(cfg_data[19:0]);
                ptc_pkg::RegTempCross:    c01_reg <= signed'(cfg_data[15:0]);
                ptc_pkg::RegMixedLinear:  c11_reg <= signed'(cfg_data[15:0]);
                ptc_pkg::RegPressSquare:  c20_reg <= signed'(cfg_data[15:0]);
                ptc_pkg::RegMixedSquare:  c21_reg <= signed'(cfg_data[15:0]);
                ptc_pkg::RegPressCube:    c30_reg <= signed'(cfg_data[15:0]);
                default:                  c30_reg <= c30_reg;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Whole pipeline moves together; it holds only while a finished result is not taken.
    logic              en;
    logic [Stages:1]   vld_reg;

    assign en        = !vld_reg[Stages] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[Stages];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-1:1], in_valid && in_ready};
        end
    end

    // ---------------- datapath ----------------
    // raw inputs ride along until the last multiply that needs them (stage 9)
    logic signed [23:0] p_reg [1:8];
    logic signed [23:0] t_reg [1:8];

    // level 1: c20 + p*c30/Kp, c11 + p*c21/Kp; also t*c01/Kt and the temperature path
    logic signed [39:0] prod_a1_reg, prod_m1_reg, prod_t1_reg;
    logic signed [35:0] prod_c1_reg;
    logic [20:0]        n_a2_reg, n_m2_reg;
    logic               neg_a2_reg, neg_m2_reg, neg_a3_reg, neg_m3_reg;
    logic [19:0]        q_a3_reg, q_m3_reg;
    logic signed [18:0] acc1_reg, mix1_reg;

    // level 2: c10 + p*acc1/Kp, p*mix1/Kp
    logic signed [42:0] prod_a5_reg, prod_m5_reg;
    logic [23:0]        n_a6_reg, n_m6_reg;
    logic               neg_a6_reg, neg_m6_reg, neg_a7_reg, neg_m7_reg;
    logic [22:0]        q_a7_reg, q_m7_reg;
    logic signed [21:0] acc2_reg, mix2_reg;

    // level 3: c00 + p*acc2/Kp, t*mix2/Kt
    logic signed [45:0] prod_a9_reg, prod_m9_reg;
    logic [26:0]        n_a10_reg;
    logic               neg_a10_reg, neg_a11_reg;
    logic [25:0]        q_a11_reg;
    logic signed [24:0] acc3_reg;

    // side terms delayed to the final sum
    logic signed [20:0] tc_reg   [2:12];
    logic signed [16:0] temp_reg [2:12];
    logic signed [25:0] mix3_reg [10:12];

    // output stage
    logic signed [31:0] pres_out_reg;
    logic signed [16:0] temp_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // delay lines
            p_reg[1] <= raw_pressure;
            t_reg[1] <= raw_temperature;
            for (int k = 2; k <= 8; k++)
            begin
                p_reg[k] <= p_reg[k-1];
                t_reg[k] <= t_reg[k-1];
            end
            for (int k = 3; k <= 12; k++)
            begin
                tc_reg[k]   <= tc_reg[k-1];
                temp_reg[k] <= temp_reg[k-1];
            end
            for (int k = 11; k <= 12; k++)
            begin
                mix3_reg[k] <= mix3_reg[k-1];
            end

            // stage 1: first products
            prod_a1_reg <= raw_pressure * c30_reg;
            prod_m1_reg <= raw_pressure * c21_reg;
            prod_t1_reg <= raw_temperature * c01_reg;
            prod_c1_reg <= raw_temperature * c1;

            // stage 2: magnitude / 2^19, truncating shifts by 2^19
            n_a2_reg    <= 21'(ptc_pkg::mag_shr(48'(prod_a1_reg)));
            neg_a2_reg  <= prod_a1_reg[39];
            n_m2_reg    <= 21'(ptc_pkg::mag_shr(48'(prod_m1_reg)));
            neg_m2_reg  <= prod_m1_reg[39];
            tc_reg[2]   <= 21'(ptc_pkg::trunc_shr(48'(prod_t1_reg)));
            temp_reg[2] <= 17'(c0_half) + 17'(ptc_pkg::trunc_shr(48'(prod_c1_reg)));

            // stage 3: divide by 3
            q_a3_reg   <= 20'(ptc_pkg::div3(29'(n_a2_reg)));
            q_m3_reg   <= 20'(ptc_pkg::div3(29'(n_m2_reg)));
            neg_a3_reg <= neg_a2_reg;
            neg_m3_reg <= neg_m2_reg;

            // stage 4: sign back, add coefficient
            acc1_reg <= 19'(29'(c20_reg) + ptc_pkg::apply_sign(28'(q_a3_reg), neg_a3_reg));
            mix1_reg <= 19'(29'(c11_reg) + ptc_pkg::apply_sign(28'(q_m3_reg), neg_m3_reg));

            // stage 5
            prod_a5_reg <= p_reg[4] * acc1_reg;
            prod_m5_reg <= p_reg[4] * mix1_reg;

            // stage 6
            n_a6_reg   <= 24'(ptc_pkg::mag_shr(48'(prod_a5_reg)));
            neg_a6_reg <= prod_a5_reg[42];
            n_m6_reg   <= 24'(ptc_pkg::mag_shr(48'(prod_m5_reg)));
            neg_m6_reg <= prod_m5_reg[42];

            // stage 7
            q_a7_reg   <= 23'(ptc_pkg::div3(29'(n_a6_reg)));
            q_m7_reg   <= 23'(ptc_pkg::div3(29'(n_m6_reg)));
            neg_a7_reg <= neg_a6_reg;
            neg_m7_reg <= neg_m6_reg;

            // stage 8
            acc2_reg <= 22'(29'(c10_reg) + ptc_pkg::apply_sign(28'(q_a7_reg), neg_a7_reg));
            mix2_reg <= 22'(ptc_pkg::apply_sign(28'(q_m7_reg), neg_m7_reg));

            // stage 9
            prod_a9_reg <= p_reg[8] * acc2_reg;
            prod_m9_reg <= t_reg[8] * mix2_reg;

            // stage 10: mixed term only needs the power-of-two divide
            n_a10_reg    <= 27'(ptc_pkg::mag_shr(48'(prod_a9_reg)));
            neg_a10_reg  <= prod_a9_reg[45];
            mix3_reg[10] <= 26'(ptc_pkg::trunc_shr(48'(prod_m9_reg)));

            // stage 11
            q_a11_reg   <= 26'(ptc_pkg::div3(29'(n_a10_reg)));
            neg_a11_reg <= neg_a10_reg;

            // stage 12
            acc3_reg <= 25'(29'(c00_reg) + ptc_pkg::apply_sign(28'(q_a11_reg), neg_a11_reg));

            // stage 13: final sum; magnitude stays well inside 32 bits
            pres_out_reg <= 32'(acc3_reg) + 32'(tc_reg[12]) + 32'(mix3_reg[12]);
            temp_out_reg <= temp_reg[12];
        end
    end

    assign comp_pressure   = pres_out_reg;
    assign temperature_deg = temp_out_reg;

endmodule
